@@ rtl/core/pfma_pkg.sv @@
package pfma_pkg;

   localparam int unsigned MODULUS   = 65521;
   localparam int unsigned DATA_W    = 16;
   localparam int unsigned PROD_W    = 2 * DATA_W;
   localparam int unsigned EXPONENT  = MODULUS - 2;
   localparam int unsigned EXP_BITS  = $clog2(EXPONENT + 1);
   localparam int unsigned FOLD_W    = DATA_W + 5;

   localparam logic [DATA_W-1:0]   MOD_VAL  = DATA_W'(MODULUS);
   localparam logic [DATA_W-1:0]   FOLD_VAL = DATA_W'((2 ** DATA_W) - MODULUS);
   localparam logic [EXP_BITS-1:0] EXP_VAL  = EXP_BITS'(EXPONENT);

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef struct packed {
      action_type        action;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              b_zero;
      logic [DATA_W-1:0] simple;
      logic [PROD_W-1:0] acc;
      logic [PROD_W-1:0] sq;
   } lane_type;

   // 2^16 = fold (mod m): fold the high half down twice, then one subtract
   function automatic logic [DATA_W-1:0] mod_reduce(input logic [PROD_W-1:0] x);
      logic [FOLD_W-1:0] t;
      logic [DATA_W:0]   u;
      t = FOLD_W'(x[PROD_W-1:DATA_W]) * FOLD_W'(FOLD_VAL) + FOLD_W'(x[DATA_W-1:0]);
      u = (DATA_W+1)'(t[FOLD_W-1:DATA_W]) * (DATA_W+1)'(FOLD_VAL)
          + (DATA_W+1)'(t[DATA_W-1:0]);
      if (u >= (DATA_W+1)'(MOD_VAL)) begin
         u = u - (DATA_W+1)'(MOD_VAL);
      end
      return u[DATA_W-1:0];
   endfunction

endpackage

@@ rtl/core/pfma_stage.sv @@
module pfma_stage import pfma_pkg::*; #(
   parameter logic EXP_BIT = 1'b1
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  lane_type in_lane,
   output logic     out_valid,
   output lane_type out_lane
);

   logic     mid_valid_ff;
   lane_type mid_lane_ff;
   lane_type mid_lane_in;
   logic     out_valid_ff;
   lane_type out_lane_ff;
   lane_type out_lane_in;

   // multiply half
   always_comb begin
      mid_lane_in = in_lane;
      if (EXP_BIT) begin
         mid_lane_in.acc = PROD_W'(in_lane.acc[DATA_W-1:0]) * PROD_W'(in_lane.sq[DATA_W-1:0]);
      end
      mid_lane_in.sq = PROD_W'(in_lane.sq[DATA_W-1:0]) * PROD_W'(in_lane.sq[DATA_W-1:0]);
   end

   // reduce half
   always_comb begin
      out_lane_in = mid_lane_ff;
      if (EXP_BIT) begin
         out_lane_in.acc = PROD_W'(mod_reduce(mid_lane_ff.acc));
      end
      out_lane_in.sq = PROD_W'(mod_reduce(mid_lane_ff.sq));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_lane_ff <= mid_lane_in;
         out_lane_ff <= out_lane_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_lane  = out_lane_ff;

endmodule

@@ rtl/core/prime_field_modular_alu.sv @@
// prime_field_modular_alu: add, subtract, multiply and divide modulo the
// prime 65521, one result beat per request beat.
// request channel: req_valid, req_action, req_operand_a, req_operand_b,
// with req_stall back to the sender. operands at or above the modulus are
// reduced first. action 0 add, 1 subtract, 2 multiply, 3 divide.
// response channel: rsp_valid, rsp_result, with rsp_stall from the receiver.
// divide takes the right operand to the power modulus minus two, one
// exponent bit per pair of stages; dividing by zero gives 0.
// pipeline: every action takes the same path from an accepted request to its
// response, through 2 input stages, 32 exponent stages
// (multiply, then reduce, for each of 16 bits) and 2 final stages.
// throughput: one beat per cycle while the receiver does not stall; each
// exponent and final stage holds 16 x 16 multiplies or fold reductions.
// when the receiver stalls a waiting response, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is lost or repeated.
// reset (synchronous, active high) empties the pipeline.
module prime_field_modular_alu import pfma_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [DATA_W-1:0] req_operand_a,
   input  logic [DATA_W-1:0] req_operand_b,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_result
);

   logic advance;

   logic              in_valid_ff;
   action_type        in_action_ff;
   logic [DATA_W-1:0] in_a_ff;
   logic [DATA_W-1:0] in_b_ff;
   logic [DATA_W-1:0] red_a;
   logic [DATA_W-1:0] red_b;

   logic              head_valid_ff;
   lane_type          head_lane_ff;
   lane_type          head_lane_in;
   logic [DATA_W:0]   sum;

   logic              stage_valid [0:EXP_BITS];
   lane_type          stage_lane  [0:EXP_BITS];

   logic              fm_valid_ff;
   lane_type          fm_lane_ff;
   logic [PROD_W-1:0] fm_prod_ff;
   logic [PROD_W-1:0] fm_prod_in;
   logic [DATA_W-1:0] pick;

   logic              out_valid_ff;
   logic [DATA_W-1:0] out_result_ff;
   logic [DATA_W-1:0] out_result_in;
   logic [DATA_W-1:0] reduced;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      red_a = (req_operand_a >= MOD_VAL) ? req_operand_a - MOD_VAL : req_operand_a;
      red_b = (req_operand_b >= MOD_VAL) ? req_operand_b - MOD_VAL : req_operand_b;
   end

   always_comb begin
      head_lane_in        = '0;
      head_lane_in.action = in_action_ff;
      head_lane_in.a      = in_a_ff;
      head_lane_in.b      = in_b_ff;
      head_lane_in.b_zero = (in_b_ff == '0);
      head_lane_in.acc    = PROD_W'(1);
      head_lane_in.sq     = PROD_W'(in_b_ff);
      sum                 = '0;
      case (in_action_ff)
         ACT_ADD: begin
            sum = (DATA_W+1)'(in_a_ff) + (DATA_W+1)'(in_b_ff);
            if (sum >= (DATA_W+1)'(MOD_VAL)) begin
               sum = sum - (DATA_W+1)'(MOD_VAL);
            end
         end
         ACT_SUB: begin
            sum = (DATA_W+1)'(in_a_ff) - (DATA_W+1)'(in_b_ff);
            if (in_a_ff < in_b_ff) begin
               sum = sum + (DATA_W+1)'(MOD_VAL);
            end
         end
         default: begin
            sum = '0;
         end
      endcase
      head_lane_in.simple = sum[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         head_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         head_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_action_ff <= action_type'(req_action);
         in_a_ff      <= red_a;
         in_b_ff      <= red_b;
         head_lane_ff <= head_lane_in;
      end
   end

   assign stage_valid[0] = head_valid_ff;
   assign stage_lane[0]  = head_lane_ff;

   for (genvar i = 0; i < EXP_BITS; i++) begin : g_exp
      pfma_stage #(
         .EXP_BIT (EXP_VAL[i])
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_lane   (stage_lane[i]),
         .out_valid (stage_valid[i+1]),
         .out_lane  (stage_lane[i+1])
      );
   end

   always_comb begin
      pick = (stage_lane[EXP_BITS].action == ACT_DIV) ?
             stage_lane[EXP_BITS].acc[DATA_W-1:0] : stage_lane[EXP_BITS].b;
      fm_prod_in = PROD_W'(stage_lane[EXP_BITS].a) * PROD_W'(pick);
   end

   always_comb begin
      reduced = mod_reduce(fm_prod_ff);
      case (fm_lane_ff.action)
         ACT_ADD, ACT_SUB: out_result_in = fm_lane_ff.simple;
         ACT_MUL:          out_result_in = reduced;
         ACT_DIV:          out_result_in = fm_lane_ff.b_zero ? '0 : reduced;
         default:          out_result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fm_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         fm_valid_ff  <= stage_valid[EXP_BITS];
         out_valid_ff <= fm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fm_lane_ff    <= stage_lane[EXP_BITS];
         fm_prod_ff    <= fm_prod_in;
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_result_ff;

endmodule

@@ rtl/core/pfma_checker.sv @@
module pfma_checker import pfma_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_action,
   input logic [DATA_W-1:0] req_operand_a,
   input logic [DATA_W-1:0] req_operand_b,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_result
);

   // held response beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("response beat changed while stalled");

   // results are always reduced
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result < MOD_VAL)
      else $error("response not reduced");

   // the pipeline only pushes back when its last beat is held
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // stalled request beat stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_action)
         && $stable(req_operand_a) && $stable(req_operand_b))
      else $error("request beat changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

endmodule

bind prime_field_modular_alu pfma_checker u_pfma_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_action    (req_action),
   .req_operand_a (req_operand_a),
   .req_operand_b (req_operand_b),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_result    (rsp_result)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import pfma_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_action;
   logic [DATA_W-1:0] req_operand_a;
   logic [DATA_W-1:0] req_operand_b;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [DATA_W-1:0] rsp_result;

   typedef struct {
      action_type        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      bit                typed;
      logic [DATA_W-1:0] want;
   } vector_type;

   logic [DATA_W-1:0] pending_results[$];
   int                mismatches = 0;
   int                n_accepted = 0;
   longint            cycles = 0;

   prime_field_modular_alu DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(rsp_result)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned field_mul(longint unsigned x, longint unsigned y);
      return (x * y) % MODULUS;
   endfunction

   function automatic logic [DATA_W-1:0] field_result(action_type op,
                                                      logic [DATA_W-1:0] a_in,
                                                      logic [DATA_W-1:0] b_in);
      longint unsigned a, b, r, acc, sq, e;
      a = longint'(a_in) % MODULUS;
      b = longint'(b_in) % MODULUS;
      case (op)
         ACT_ADD: r = (a + b) % MODULUS;
         ACT_SUB: r = (a + MODULUS - b) % MODULUS;
         ACT_MUL: r = field_mul(a, b);
         default: begin
            if (b == 0) begin
               r = 0;
            end else begin
               acc = 1;
               sq = b;
               e = MODULUS - 2;
               while (e != 0) begin
                  if (e[0]) acc = field_mul(acc, sq);
                  sq = field_mul(sq, sq);
                  e = e >> 1;
               end
               r = field_mul(a, acc);
            end
         end
      endcase
      return r[DATA_W-1:0];
   endfunction

   task automatic send_beat(action_type op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                            bit typed, logic [DATA_W-1:0] want);
      req_valid <= 1'b1;
      req_action <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results = {pending_results, (typed ? want : field_result(op, a, b))};
      n_accepted++;
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [DATA_W-1:0] rand_operand();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return DATA_W'($urandom_range(65521, 65535));
      if (pick == 1) return '0;
      if (pick == 2) return DATA_W'(65520);
      return DATA_W'($urandom_range(0, 65520));
   endfunction

   vector_type directed[] = '{
      '{ACT_ADD, 16'd0,     16'd0,     1, 16'd0},
      '{ACT_ADD, 16'd65520, 16'd65520, 1, 16'd65519},
      '{ACT_ADD, 16'd65535, 16'd65535, 1, 16'd28},
      '{ACT_ADD, 16'd65535, 16'd0,     1, 16'd14},
      '{ACT_SUB, 16'd0,     16'd65520, 1, 16'd1},
      '{ACT_SUB, 16'd65520, 16'd0,     1, 16'd65520},
      '{ACT_SUB, 16'd65521, 16'd0,     1, 16'd0},
      '{ACT_SUB, 16'd3,     16'd65535, 1, 16'd65510},
      '{ACT_MUL, 16'd65520, 16'd65520, 1, 16'd1},
      '{ACT_MUL, 16'd65535, 16'd65535, 1, 16'd196},
      '{ACT_MUL, 16'd0,     16'd65520, 1, 16'd0},
      '{ACT_MUL, 16'd12345, 16'd54321, 0, 16'd0},
      '{ACT_DIV, 16'd0,     16'd0,     1, 16'd0},
      '{ACT_DIV, 16'd5,     16'd0,     1, 16'd0},
      '{ACT_DIV, 16'd777,   16'd65521, 1, 16'd0},
      '{ACT_DIV, 16'd1,     16'd1,     1, 16'd1},
      '{ACT_DIV, 16'd65520, 16'd65520, 1, 16'd1},
      '{ACT_DIV, 16'd7,     16'd3,     0, 16'd0},
      '{ACT_DIV, 16'd65535, 16'd65534, 0, 16'd0},
      '{ACT_DIV, 16'd1,     16'd2,     0, 16'd0}
   };

   // sender
   initial begin
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send_beat(directed[i].op, directed[i].a, directed[i].b,
                   directed[i].typed, directed[i].want);
         if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
      end
      // drain before random traffic
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      for (int n = 0; n < 550; ) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && n < 550; k++, n++) begin
            send_beat(action_type'($urandom_range(0, 3)), rand_operand(), rand_operand(), 0, '0);
         end
         idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10));
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int mode;
      bit held;
      held = 0;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         for (int c = 0; c < 64; c++) begin
            @(posedge clock);
            if (!held && n_accepted >= 200) begin
               held = 1;
               rsp_stall <= 1'b1;
               repeat (250) @(posedge clock);
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= $urandom_range(0, 1);
            endcase
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing pending: %0d", rsp_result);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result !== want) begin
               $error("result: expected %0d, got %0d", want, rsp_result);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
